/* src/rldm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rldm_pkg: shared types and constants for the radial lens distortion map
// Sequencer states, arithmetic unit request/response and fixed-point helpers.
// ----------------------------------------------------------------------------
package rldm_pkg;

	// saturation bound of shifted products, quotients and clamped values, 2^60
	localparam logic [63:0]        SAT_LIM  = 64'h1000_0000_0000_0000;
	localparam logic signed [63:0] SAT_POS  = 64'sh1000_0000_0000_0000;
	localparam logic signed [63:0] SAT_NEG  = -64'sh1000_0000_0000_0000;
	localparam logic signed [63:0] ONE_Q32  = 64'sh0000_0001_0000_0000;
	localparam logic signed [63:0] ONE_Q31  = 64'sh0000_0000_8000_0000;
	localparam logic [63:0]        TINY_SQ  = 64'd281;
	localparam logic [63:0]        LSB_Q32  = 64'd256;
	// start guess ru*8/70 = floor(4*ru/35); ceil(2^50/35) is exact for 4*ru < 2^42
	localparam logic [63:0]        RD0_RECIP = 64'd32168568766933;
	localparam logic [5:0]         RD0_SHIFT = 6'd50;

	localparam logic signed [31:0] RST_COEFF_SQUARE = -32'sd21260088;
	localparam logic signed [31:0] RST_COEFF_CUBE   = -32'sd1073742;

	localparam logic [7:0] REG_COEFF_SQUARE = 8'd0;
	localparam logic [7:0] REG_COEFF_CUBE   = 8'd1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ZERO_F  = 2'd1;
	localparam logic [1:0] ST_NO_CONV = 2'd2;

	// arithmetic unit timing
	localparam int          DIV_BITS  = 96;
	localparam logic [6:0]  MUL_LAST  = 7'd3;
	localparam logic [6:0]  DIV_LAST  = 7'(DIV_BITS - 1);
	localparam logic [6:0]  SQRT_LAST = 7'd31;
	localparam logic [63:0] SQRT_TOP  = 64'h4000_0000_0000_0000;

	typedef enum logic [1:0] {
		AOP_MUL,
		AOP_DIV,
		AOP_SQRT
	} aop_t;

	typedef enum logic [2:0] {
		AU_IDLE,
		AU_MUL,
		AU_DIV,
		AU_SQRT,
		AU_FIN
	} au_state_t;

	typedef enum logic [4:0] {
		SEQ_IDLE,
		SEQ_SQX,
		SEQ_SQY,
		SEQ_SQRT,
		SEQ_U_R3,
		SEQ_U_T1,
		SEQ_U_T2,
		SEQ_U_DX,
		SEQ_U_DY,
		SEQ_D_RD0,
		SEQ_D_CHK,
		SEQ_D_RD2,
		SEQ_D_RD3,
		SEQ_D_T1,
		SEQ_D_T2,
		SEQ_D_Q,
		SEQ_D_T3,
		SEQ_D_T4,
		SEQ_D_T5,
		SEQ_D_TSQ,
		SEQ_D_DER,
		SEQ_D_DEL,
		SEQ_D_MUL,
		SEQ_D_XO,
		SEQ_D_YO,
		SEQ_OUT
	} seq_state_t;

	typedef struct packed {
		logic        start;
		aop_t        op;
		logic [63:0] a;
		logic [63:0] b;
		logic [5:0]  sh;
	} arith_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} arith_rsp_t;

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		logic [63:0] u;
		u = v;
		return v[63] ? (~u + 64'd1) : u;
	endfunction

	function automatic logic signed [63:0] with_sign(input logic [63:0] m, input logic neg);
		logic signed [63:0] s;
		s = $signed(m);
		return neg ? -s : s;
	endfunction

	function automatic logic signed [63:0] clamp60(input logic signed [63:0] v);
		logic signed [63:0] r;
		r = v;
		if (v > SAT_POS) r = SAT_POS;
		if (v < SAT_NEG) r = SAT_NEG;
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		r = v[31:0];
		if (v > 64'sd2147483647) r = 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) r = 32'sh8000_0000;
		return r;
	endfunction

endpackage

/* src/rldm_arith.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rldm_arith: shared multi-cycle arithmetic unit
// 64x64 multiply from four 32x32 partial products with shift and saturation,
// radix-2 restoring divide of (a << sh) / b, and a bit-pair integer root.
// ----------------------------------------------------------------------------
module rldm_arith (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rldm_pkg::arith_req_t   req,
	output rldm_pkg::arith_rsp_t   rsp
);

	rldm_pkg::au_state_t state_q, state_d;
	rldm_pkg::aop_t      op_q;
	logic [6:0]   cnt_q;
	logic [63:0]  a_q, b_q;
	logic [5:0]   sh_q;
	logic [127:0] prod_q;
	logic [rldm_pkg::DIV_BITS-1:0] dvd_q;
	logic [64:0]  rem_q;
	logic [61:0]  quo_q;
	logic         over_q;
	logic [63:0]  sqv_q, sqr_q, sqb_q;

	logic [31:0]  ah, bh;
	logic [63:0]  pp;
	logic [127:0] pp_sh, prod_sft;
	logic [65:0]  rem_sh, rem_nx;
	logic         div_ge;
	logic [61:0]  quo_nx;
	logic [64:0]  sq_t;
	logic         sq_ge;
	logic [63:0]  fin_res;

	// datapath
	always_comb begin
		ah = cnt_q[1] ? a_q[63:32] : a_q[31:0];
		bh = cnt_q[0] ? b_q[63:32] : b_q[31:0];
		pp = ah * bh;
		case (cnt_q[1:0])
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		rem_sh = {rem_q, dvd_q[rldm_pkg::DIV_BITS-1]};
		div_ge = rem_sh >= {2'b00, b_q};
		rem_nx = div_ge ? (rem_sh - {2'b00, b_q}) : rem_sh;
		quo_nx = {quo_q[60:0], div_ge};
		sq_t   = {1'b0, sqr_q} + {1'b0, sqb_q};
		sq_ge  = {1'b0, sqv_q} >= sq_t;
		prod_sft = prod_q >> sh_q;
		case (op_q)
			rldm_pkg::AOP_MUL: begin
				if (sh_q == 6'd0)
					fin_res = prod_q[63:0];
				else if (prod_sft > {64'd0, rldm_pkg::SAT_LIM})
					fin_res = rldm_pkg::SAT_LIM;
				else
					fin_res = prod_sft[63:0];
			end
			rldm_pkg::AOP_DIV:  fin_res = over_q ? rldm_pkg::SAT_LIM : {2'b00, quo_q};
			rldm_pkg::AOP_SQRT: fin_res = sqr_q;
			default:            fin_res = 64'd0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rldm_pkg::AU_IDLE: begin
				if (req.start) begin
					case (req.op)
						rldm_pkg::AOP_MUL:  state_d = rldm_pkg::AU_MUL;
						rldm_pkg::AOP_DIV:  state_d = rldm_pkg::AU_DIV;
						rldm_pkg::AOP_SQRT: state_d = rldm_pkg::AU_SQRT;
						default:            state_d = rldm_pkg::AU_IDLE;
					endcase
				end
			end
			rldm_pkg::AU_MUL:  if (cnt_q == rldm_pkg::MUL_LAST) state_d = rldm_pkg::AU_FIN;
			rldm_pkg::AU_DIV:  if (cnt_q == rldm_pkg::DIV_LAST) state_d = rldm_pkg::AU_FIN;
			rldm_pkg::AU_SQRT: if (cnt_q == rldm_pkg::SQRT_LAST) state_d = rldm_pkg::AU_FIN;
			rldm_pkg::AU_FIN:  state_d = rldm_pkg::AU_IDLE;
			default:           state_d = rldm_pkg::AU_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		rsp.done = (state_q == rldm_pkg::AU_FIN);
		rsp.res  = fin_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rldm_pkg::AU_IDLE;
			cnt_q   <= 7'd0;
		end else begin
			state_q <= state_d;
			if (state_q == rldm_pkg::AU_IDLE)
				cnt_q <= 7'd0;
			else
				cnt_q <= cnt_q + 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rldm_pkg::AU_IDLE: begin
				if (req.start) begin
					op_q   <= req.op;
					a_q    <= req.a;
					b_q    <= req.b;
					sh_q   <= req.sh;
					prod_q <= 128'd0;
					dvd_q  <= rldm_pkg::DIV_BITS'({32'd0, req.a} << req.sh);
					rem_q  <= 65'd0;
					quo_q  <= 62'd0;
					over_q <= 1'b0;
					sqv_q  <= req.a;
					sqr_q  <= 64'd0;
					sqb_q  <= rldm_pkg::SQRT_TOP;
				end
			end
			rldm_pkg::AU_MUL: prod_q <= prod_q + pp_sh;
			rldm_pkg::AU_DIV: begin
				rem_q <= rem_nx[64:0];
				dvd_q <= dvd_q << 1;
				if (!over_q) begin
					quo_q <= quo_nx;
					if (quo_nx > 62'(rldm_pkg::SAT_LIM)) over_q <= 1'b1;
				end
			end
			rldm_pkg::AU_SQRT: begin
				if (sq_ge) begin
					sqv_q <= sqv_q - sq_t[63:0];
					sqr_q <= (sqr_q >> 1) + sqb_q;
				end else begin
					sqr_q <= sqr_q >> 1;
				end
				sqb_q <= sqb_q >> 2;
			end
			default: ;
		endcase
	end

endmodule

/* src/radial_lens_distortion_map.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radial_lens_distortion_map: radial lens distortion and its Newton inverse
// Maps one focal-plane point (Q7.24 mm) per transfer; coefficients are Q0.31.
// ----------------------------------------------------------------------------
// One point at a time passes through a sequencer that drives a single shared
// arithmetic unit (multiply, divide and square root). Every point first
// computes x^2+y^2, then its root. Removing distortion adds three products
// and two divides. Applying distortion adds a start guess (a reciprocal
// multiply), eight products and three divides per Newton step, up to
// MAX_STEPS+1 steps, and a final scaling; when applying distortion, points
// within 1e-6 mm of the axis return unchanged and skip the root.
// in_stall stays high from the input transfer until the result is loaded
// into the output register; a waiting result does not hold back the next
// input transfer.
// Coefficient writes are always accepted (cfg_ready is tied high) and should
// only be issued while the block is idle. Status: 0 ok, 1 zero distortion
// factor, 2 no convergence; on status 1 or 2 the coordinates read zero.
// ----------------------------------------------------------------------------
module radial_lens_distortion_map #(
	parameter int MAX_STEPS = 50
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic signed [31:0] x_in,
	input  logic signed [31:0] y_in,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] x_out,
	output logic signed [31:0] y_out,
	output logic [1:0]         status,
	// coefficient writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int ITER_W = $clog2(MAX_STEPS + 2);

	rldm_pkg::seq_state_t state_q, state_d;
	rldm_pkg::arith_req_t req;
	rldm_pkg::arith_rsp_t rsp;

	logic                   issued_q;
	logic                   out_valid_q;
	logic signed [31:0]     cs_q, cc_q;
	logic                   op_q;
	logic signed [31:0]     x_q, y_q;
	logic [63:0]            r2_q;
	logic [31:0]            root_q;
	logic signed [63:0]     ru_q, rd_q, delta_q, rd2_q, rd3_q, acc_q;
	logic signed [63:0]     temp_q, frd_q, num_q, tsq_q, deriv_q;
	logic [ITER_W-1:0]      iter_q;
	logic signed [63:0]     xo_q, yo_q;
	logic [1:0]             st_q;
	logic signed [31:0]     x_out_q, y_out_q;
	logic [1:0]             status_q;

	logic signed [63:0]     x64, y64, cs64, cc64, cs2, cc3, sval;
	logic                   neg_c, skip_c, fail_c, tiny_c, conv_c, blow_c;
	logic [1:0]             fail_code;

	rldm_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign x64  = {{32{x_q[31]}}, x_q};
	assign y64  = {{32{y_q[31]}}, y_q};
	assign cs64 = {{32{cs_q[31]}}, cs_q};
	assign cc64 = {{32{cc_q[31]}}, cc_q};
	assign cs2  = cs64 <<< 1;
	assign cc3  = cc64 + (cc64 <<< 1);
	assign sval = rldm_pkg::with_sign(rsp.res, neg_c);

	assign in_stall  = (state_q != rldm_pkg::SEQ_IDLE);
	assign out_valid = out_valid_q;
	assign x_out     = x_out_q;
	assign y_out     = y_out_q;
	assign status    = status_q;
	assign cfg_ready = 1'b1;

	// guard conditions
	assign tiny_c = op_q && (r2_q <= rldm_pkg::TINY_SQ);
	assign conv_c = rldm_pkg::mag64(delta_q) < rldm_pkg::LSB_Q32;
	assign blow_c = (rldm_pkg::mag64(delta_q) >= rldm_pkg::SAT_LIM) ||
	                (iter_q > ITER_W'(MAX_STEPS));

	// per-state checks: skip_c holds off the unit, fail_c ends the point early
	always_comb begin
		skip_c    = 1'b0;
		fail_c    = 1'b0;
		fail_code = rldm_pkg::ST_NO_CONV;
		case (state_q)
			rldm_pkg::SEQ_SQRT: skip_c = tiny_c;
			rldm_pkg::SEQ_U_DX: begin
				skip_c    = (acc_q == 64'sd0);
				fail_c    = skip_c;
				fail_code = rldm_pkg::ST_ZERO_F;
			end
			rldm_pkg::SEQ_D_CHK: begin
				skip_c = 1'b1;
				fail_c = !conv_c && blow_c;
			end
			rldm_pkg::SEQ_D_Q: begin
				skip_c = (temp_q == 64'sd0);
				fail_c = skip_c;
			end
			rldm_pkg::SEQ_D_DER: begin
				skip_c = (tsq_q == 64'sd0);
				fail_c = skip_c;
			end
			rldm_pkg::SEQ_D_DEL: begin
				skip_c = (deriv_q == 64'sd0);
				fail_c = skip_c;
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			rldm_pkg::SEQ_IDLE:  if (in_valid) state_d = rldm_pkg::SEQ_SQX;
			rldm_pkg::SEQ_SQX:   if (rsp.done) state_d = rldm_pkg::SEQ_SQY;
			rldm_pkg::SEQ_SQY:   if (rsp.done) state_d = rldm_pkg::SEQ_SQRT;
			rldm_pkg::SEQ_SQRT: begin
				if (tiny_c)
					state_d = rldm_pkg::SEQ_OUT;
				else if (rsp.done)
					state_d = op_q ? rldm_pkg::SEQ_D_RD0 : rldm_pkg::SEQ_U_R3;
			end
			rldm_pkg::SEQ_U_R3:  if (rsp.done) state_d = rldm_pkg::SEQ_U_T1;
			rldm_pkg::SEQ_U_T1:  if (rsp.done) state_d = rldm_pkg::SEQ_U_T2;
			rldm_pkg::SEQ_U_T2:  if (rsp.done) state_d = rldm_pkg::SEQ_U_DX;
			rldm_pkg::SEQ_U_DX: begin
				if (fail_c)        state_d = rldm_pkg::SEQ_OUT;
				else if (rsp.done) state_d = rldm_pkg::SEQ_U_DY;
			end
			rldm_pkg::SEQ_U_DY:  if (rsp.done) state_d = rldm_pkg::SEQ_OUT;
			rldm_pkg::SEQ_D_RD0: if (rsp.done) state_d = rldm_pkg::SEQ_D_CHK;
			rldm_pkg::SEQ_D_CHK: begin
				if (conv_c)      state_d = rldm_pkg::SEQ_D_MUL;
				else if (fail_c) state_d = rldm_pkg::SEQ_OUT;
				else             state_d = rldm_pkg::SEQ_D_RD2;
			end
			rldm_pkg::SEQ_D_RD2: if (rsp.done) state_d = rldm_pkg::SEQ_D_RD3;
			rldm_pkg::SEQ_D_RD3: if (rsp.done) state_d = rldm_pkg::SEQ_D_T1;
			rldm_pkg::SEQ_D_T1:  if (rsp.done) state_d = rldm_pkg::SEQ_D_T2;
			rldm_pkg::SEQ_D_T2:  if (rsp.done) state_d = rldm_pkg::SEQ_D_Q;
			rldm_pkg::SEQ_D_Q: begin
				if (fail_c)        state_d = rldm_pkg::SEQ_OUT;
				else if (rsp.done) state_d = rldm_pkg::SEQ_D_T3;
			end
			rldm_pkg::SEQ_D_T3:  if (rsp.done) state_d = rldm_pkg::SEQ_D_T4;
			rldm_pkg::SEQ_D_T4:  if (rsp.done) state_d = rldm_pkg::SEQ_D_T5;
			rldm_pkg::SEQ_D_T5:  if (rsp.done) state_d = rldm_pkg::SEQ_D_TSQ;
			rldm_pkg::SEQ_D_TSQ: if (rsp.done) state_d = rldm_pkg::SEQ_D_DER;
			rldm_pkg::SEQ_D_DER: begin
				if (fail_c)        state_d = rldm_pkg::SEQ_OUT;
				else if (rsp.done) state_d = rldm_pkg::SEQ_D_DEL;
			end
			rldm_pkg::SEQ_D_DEL: begin
				if (fail_c)        state_d = rldm_pkg::SEQ_OUT;
				else if (rsp.done) state_d = rldm_pkg::SEQ_D_CHK;
			end
			rldm_pkg::SEQ_D_MUL: if (rsp.done) state_d = rldm_pkg::SEQ_D_XO;
			rldm_pkg::SEQ_D_XO:  if (rsp.done) state_d = rldm_pkg::SEQ_D_YO;
			rldm_pkg::SEQ_D_YO:  if (rsp.done) state_d = rldm_pkg::SEQ_OUT;
			rldm_pkg::SEQ_OUT:   if (!out_valid_q || !out_stall) state_d = rldm_pkg::SEQ_IDLE;
			default:             state_d = rldm_pkg::SEQ_IDLE;
		endcase
	end

	// unit request per state: operand magnitudes, shift, result sign
	always_comb begin
		req.op = rldm_pkg::AOP_MUL;
		req.a  = 64'd0;
		req.b  = 64'd0;
		req.sh = 6'd0;
		neg_c  = 1'b0;
		case (state_q)
			rldm_pkg::SEQ_SQX: begin
				req.a = rldm_pkg::mag64(x64);
				req.b = rldm_pkg::mag64(x64);
			end
			rldm_pkg::SEQ_SQY: begin
				req.a = rldm_pkg::mag64(y64);
				req.b = rldm_pkg::mag64(y64);
			end
			rldm_pkg::SEQ_SQRT: begin
				req.op = rldm_pkg::AOP_SQRT;
				req.a  = r2_q;
			end
			rldm_pkg::SEQ_U_R3: begin
				req.a  = r2_q;
				req.b  = {32'd0, root_q};
				req.sh = 6'd48;
			end
			rldm_pkg::SEQ_U_T1: begin
				req.a  = rldm_pkg::mag64(cs64);
				req.b  = r2_q >> 1;
				req.sh = 6'd47;
				neg_c  = cs_q[31];
			end
			rldm_pkg::SEQ_U_T2: begin
				req.a  = rldm_pkg::mag64(cc64);
				req.b  = rd3_q;
				req.sh = 6'd24;
				neg_c  = cc_q[31];
			end
			rldm_pkg::SEQ_U_DX: begin
				req.op = rldm_pkg::AOP_DIV;
				req.a  = rldm_pkg::mag64(x64);
				req.b  = rldm_pkg::mag64(acc_q);
				req.sh = 6'd31;
				neg_c  = x_q[31] ^ acc_q[63];
			end
			rldm_pkg::SEQ_U_DY: begin
				req.op = rldm_pkg::AOP_DIV;
				req.a  = rldm_pkg::mag64(y64);
				req.b  = rldm_pkg::mag64(acc_q);
				req.sh = 6'd31;
				neg_c  = y_q[31] ^ acc_q[63];
			end
			rldm_pkg::SEQ_D_RD0: begin
				// start guess ru*8/70 as (4*ru * ceil(2^50/35)) >> 50
				req.a  = {ru_q[61:0], 2'b00};
				req.b  = rldm_pkg::RD0_RECIP;
				req.sh = rldm_pkg::RD0_SHIFT;
			end
			rldm_pkg::SEQ_D_RD2: begin
				req.a  = rldm_pkg::mag64(rd_q);
				req.b  = rldm_pkg::mag64(rd_q);
				req.sh = 6'd32;
			end
			rldm_pkg::SEQ_D_RD3: begin
				req.a  = rldm_pkg::mag64(rd2_q);
				req.b  = rldm_pkg::mag64(rd_q);
				req.sh = 6'd32;
				neg_c  = rd2_q[63] ^ rd_q[63];
			end
			rldm_pkg::SEQ_D_T1: begin
				req.a  = rldm_pkg::mag64(cs64);
				req.b  = rldm_pkg::mag64(rd2_q);
				req.sh = 6'd31;
				neg_c  = cs_q[31] ^ rd2_q[63];
			end
			rldm_pkg::SEQ_D_T2: begin
				req.a  = rldm_pkg::mag64(cc64);
				req.b  = rldm_pkg::mag64(rd3_q);
				req.sh = 6'd31;
				neg_c  = cc_q[31] ^ rd3_q[63];
			end
			rldm_pkg::SEQ_D_Q: begin
				req.op = rldm_pkg::AOP_DIV;
				req.a  = rldm_pkg::mag64(rd_q);
				req.b  = rldm_pkg::mag64(temp_q);
				req.sh = 6'd32;
				neg_c  = rd_q[63] ^ temp_q[63];
			end
			rldm_pkg::SEQ_D_T3: begin
				req.a  = rldm_pkg::mag64(cs2);
				req.b  = rldm_pkg::mag64(rd_q);
				req.sh = 6'd31;
				neg_c  = cs2[63] ^ rd_q[63];
			end
			rldm_pkg::SEQ_D_T4: begin
				req.a  = rldm_pkg::mag64(cc3);
				req.b  = rldm_pkg::mag64(rd2_q);
				req.sh = 6'd31;
				neg_c  = cc3[63] ^ rd2_q[63];
			end
			rldm_pkg::SEQ_D_T5: begin
				req.a  = rldm_pkg::mag64(rd_q);
				req.b  = rldm_pkg::mag64(acc_q);
				req.sh = 6'd32;
				neg_c  = rd_q[63] ^ acc_q[63];
			end
			rldm_pkg::SEQ_D_TSQ: begin
				req.a  = rldm_pkg::mag64(temp_q);
				req.b  = rldm_pkg::mag64(temp_q);
				req.sh = 6'd32;
			end
			rldm_pkg::SEQ_D_DER: begin
				req.op = rldm_pkg::AOP_DIV;
				req.a  = rldm_pkg::mag64(num_q);
				req.b  = rldm_pkg::mag64(tsq_q);
				req.sh = 6'd32;
				neg_c  = num_q[63] ^ tsq_q[63];
			end
			rldm_pkg::SEQ_D_DEL: begin
				req.op = rldm_pkg::AOP_DIV;
				req.a  = rldm_pkg::mag64(frd_q);
				req.b  = rldm_pkg::mag64(deriv_q);
				req.sh = 6'd32;
				neg_c  = frd_q[63] ^ deriv_q[63];
			end
			rldm_pkg::SEQ_D_MUL: begin
				// scale factor rd/ru
				req.op = rldm_pkg::AOP_DIV;
				req.a  = rldm_pkg::mag64(rd_q);
				req.b  = ru_q;
				req.sh = 6'd32;
				neg_c  = rd_q[63];
			end
			rldm_pkg::SEQ_D_XO: begin
				req.a  = rldm_pkg::mag64(x64);
				req.b  = rldm_pkg::mag64(acc_q);
				req.sh = 6'd32;
				neg_c  = x_q[31] ^ acc_q[63];
			end
			rldm_pkg::SEQ_D_YO: begin
				req.a  = rldm_pkg::mag64(y64);
				req.b  = rldm_pkg::mag64(acc_q);
				req.sh = 6'd32;
				neg_c  = y_q[31] ^ acc_q[63];
			end
			default: ;
		endcase
		req.start = !issued_q && !skip_c &&
		            (state_q != rldm_pkg::SEQ_IDLE) && (state_q != rldm_pkg::SEQ_OUT);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rldm_pkg::SEQ_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
			cs_q        <= rldm_pkg::RST_COEFF_SQUARE;
			cc_q        <= rldm_pkg::RST_COEFF_CUBE;
		end else begin
			state_q <= state_d;
			if (rsp.done)
				issued_q <= 1'b0;
			else if (req.start)
				issued_q <= 1'b1;
			if (state_q == rldm_pkg::SEQ_OUT && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					rldm_pkg::REG_COEFF_SQUARE: cs_q <= cfg_data;
					rldm_pkg::REG_COEFF_CUBE:   cc_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// working registers, written on input capture, early exit, output load and when the unit returns a result
	always_ff @(posedge clk) begin
		if (state_q == rldm_pkg::SEQ_IDLE && in_valid) begin
			op_q <= operation;
			x_q  <= x_in;
			y_q  <= y_in;
		end
		if (fail_c) begin
			st_q <= fail_code;
			xo_q <= 64'sd0;
			yo_q <= 64'sd0;
		end
		if (state_q == rldm_pkg::SEQ_SQRT && tiny_c) begin
			// near the axis: point passes unchanged
			st_q <= rldm_pkg::ST_OK;
			xo_q <= x64;
			yo_q <= y64;
		end
		if (state_q == rldm_pkg::SEQ_OUT && (!out_valid_q || !out_stall)) begin
			x_out_q  <= rldm_pkg::sat32(xo_q);
			y_out_q  <= rldm_pkg::sat32(yo_q);
			status_q <= st_q;
		end
		if (rsp.done) begin
			case (state_q)
				rldm_pkg::SEQ_SQX:   r2_q <= rsp.res;
				rldm_pkg::SEQ_SQY:   r2_q <= r2_q + rsp.res;
				rldm_pkg::SEQ_SQRT: begin
					root_q <= rsp.res[31:0];
					ru_q   <= $signed({24'd0, rsp.res[31:0], 8'd0});
				end
				rldm_pkg::SEQ_U_R3:  rd3_q <= $signed(rsp.res);
				rldm_pkg::SEQ_U_T1:  acc_q <= rldm_pkg::ONE_Q31 + sval;
				rldm_pkg::SEQ_U_T2:  acc_q <= acc_q + sval;
				rldm_pkg::SEQ_U_DX:  xo_q  <= sval;
				rldm_pkg::SEQ_U_DY: begin
					yo_q <= sval;
					st_q <= rldm_pkg::ST_OK;
				end
				rldm_pkg::SEQ_D_RD0: begin
					rd_q    <= sval;
					delta_q <= rldm_pkg::ONE_Q32;
					iter_q  <= '0;
				end
				rldm_pkg::SEQ_D_RD2: rd2_q  <= sval;
				rldm_pkg::SEQ_D_RD3: rd3_q  <= sval;
				rldm_pkg::SEQ_D_T1:  acc_q  <= rldm_pkg::ONE_Q32 + sval;
				rldm_pkg::SEQ_D_T2:  temp_q <= rldm_pkg::clamp60(acc_q + sval);
				rldm_pkg::SEQ_D_Q:   frd_q  <= rldm_pkg::clamp60(sval - ru_q);
				rldm_pkg::SEQ_D_T3:  acc_q  <= sval;
				rldm_pkg::SEQ_D_T4:  acc_q  <= rldm_pkg::clamp60(acc_q + sval);
				rldm_pkg::SEQ_D_T5:  num_q  <= rldm_pkg::clamp60(temp_q - sval);
				rldm_pkg::SEQ_D_TSQ: tsq_q  <= sval;
				rldm_pkg::SEQ_D_DER: deriv_q <= sval;
				rldm_pkg::SEQ_D_DEL: begin
					delta_q <= sval;
					rd_q    <= rldm_pkg::clamp60(rd_q - sval);
					iter_q  <= iter_q + 1'b1;
				end
				rldm_pkg::SEQ_D_MUL: acc_q <= sval;
				rldm_pkg::SEQ_D_XO:  xo_q  <= sval;
				rldm_pkg::SEQ_D_YO: begin
					yo_q <= sval;
					st_q <= rldm_pkg::ST_OK;
				end
				default: ;
			endcase
		end
	end

	// the unit only answers requests that were issued
	a_done_issued: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> issued_q)
		else $error("arith result without a pending request");

	// Newton estimate stays within saturation bounds
	a_rd_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rldm_pkg::SEQ_D_CHK) |->
		((rd_q <= rldm_pkg::SAT_POS) && (rd_q >= rldm_pkg::SAT_NEG)))
		else $error("Newton radius out of range");

	// a step only starts within the step budget
	a_iter_budget: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rldm_pkg::SEQ_D_RD2) |-> (iter_q <= ITER_W'(MAX_STEPS)))
		else $error("Newton step beyond budget");

	// a presented result carries a defined status
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((status_q == rldm_pkg::ST_OK) ||
		(status_q == rldm_pkg::ST_ZERO_F) || (status_q == rldm_pkg::ST_NO_CONV)))
		else $error("undefined status code");

	// an input transfer starts the squaring step
	a_start_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == rldm_pkg::SEQ_SQX))
		else $error("input transfer did not start the sequence");

endmodule
